// File: rtl/rad_pkg.sv
// rad_pkg: shared types and constants of the rotation angle ALU.
// Holds command codes, payload structs and the pipeline context record.
// Depends on nothing; rad_ctx_pipe and rotation_angle_alu refer to it by scoped names.
package rad_pkg;

  localparam int ANG_W   = 32;   // angle parts and scalar values
  localparam int SCALE_W = 31;   // scale register
  localparam int PROD_W  = 51;   // |rotations| * 360000 magnitude
  localparam int DIV_W   = 19;   // 360000 / scale for valid scales
  localparam int K_W     = 13;   // rotations folded out by one normalize

  localparam int CHAIN1_LEN = PROD_W;
  localparam int CHAIN2_LEN = ANG_W;

  localparam logic signed [ANG_W-1:0] MDEG_ROT    = 32'sd360000;
  localparam logic signed [ANG_W-1:0] HALF_ROT    = 32'sd180000;
  localparam logic signed [ANG_W-1:0] SMALL_LIMIT = 32'sd2981;
  localparam logic [SCALE_W-1:0]      SCALE_RESET = 31'd1000;
  localparam logic [SCALE_W-1:0]      SCALE_MAX   = 31'd360000;
  localparam logic [PROD_W-1:0]       MDEG_ROT_P  = 51'd360000;

  typedef enum logic [2:0] {
    CMD_DIFF         = 3'd0,
    CMD_SUM          = 3'd1,
    CMD_AVG          = 3'd2,
    CMD_ADD_MDEG     = 3'd3,
    CMD_NEGATE       = 3'd4,
    CMD_TO_LOW_RES   = 3'd5,
    CMD_FROM_LOW_RES = 3'd6
  } rad_cmd_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [ANG_W-1:0]  a_rotations;
    logic signed [ANG_W-1:0]  a_millideg;
    logic signed [ANG_W-1:0]  b_rotations;
    logic signed [ANG_W-1:0]  b_millideg;
    logic signed [ANG_W-1:0]  value_in;
  } rad_in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0]  res_rotations;
    logic signed [ANG_W-1:0]  res_millideg;
    logic signed [ANG_W-1:0]  value_out;
    logic                     diff_small;
  } rad_out_t;

  // Item context carried alongside the divider cells.
  typedef struct packed {
    rad_cmd_t                 cmd;
    logic signed [ANG_W-1:0]  r;
    logic signed [ANG_W-1:0]  m;
    logic signed [ANG_W-1:0]  v;
    logic signed [ANG_W-1:0]  vin;
    logic [DIV_W-1:0]         d;
    logic                     neg_a;
    logic                     neg_b;
    logic                     ok;
    logic                     near_zero;
  } rad_ctx_t;

endpackage

// File: rtl/rad_div_cell.sv
// rad_div_cell: one restoring-division step, registered.
// Shifts one dividend bit into the partial remainder and one quotient bit out.
// Depends on nothing.
module rad_div_cell #(
  parameter int N = 51,
  parameter int D = 31
) (
  input  logic         clk,
  input  logic         en,
  input  logic [D-1:0] rem_i,
  input  logic [N-1:0] dvd_i,
  input  logic [D-1:0] dsr_i,
  output logic [D-1:0] rem_o,
  output logic [N-1:0] dvd_o,
  output logic [D-1:0] dsr_o
);

  logic [D:0]   trial;
  logic [D:0]   diff;
  logic         ge;
  logic [D-1:0] rem_r;
  logic [N-1:0] dvd_r;
  logic [D-1:0] dsr_r;

  assign trial = {rem_i, dvd_i[N-1]};
  assign diff  = trial - {1'b0, dsr_i};
  assign ge    = (trial >= {1'b0, dsr_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[D-1:0] : trial[D-1:0];
      dvd_r <= {dvd_i[N-2:0], ge};
      dsr_r <= dsr_i;
    end
  end

  assign rem_o = rem_r;
  assign dvd_o = dvd_r;
  assign dsr_o = dsr_r;

endmodule

// File: rtl/rad_div_chain.sv
// rad_div_chain: a row of N division cells, one quotient bit per cell.
// Gives an unsigned quotient and remainder at the end of the row.
// Depends on rad_div_cell.
module rad_div_chain #(
  parameter int N = 51,
  parameter int D = 31
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dvd_i,
  input  logic [D-1:0] dsr_i,
  output logic [N-1:0] quo_o,
  output logic [D-1:0] rem_o
);

  logic [D-1:0] rem_s [0:N];
  logic [N-1:0] dvd_s [0:N];
  logic [D-1:0] dsr_s [0:N];

  assign rem_s[0] = '0;
  assign dvd_s[0] = dvd_i;
  assign dsr_s[0] = dsr_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rad_div_cell #(.N(N), .D(D)) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_s[i]),
      .dvd_i (dvd_s[i]),
      .dsr_i (dsr_s[i]),
      .rem_o (rem_s[i+1]),
      .dvd_o (dvd_s[i+1]),
      .dsr_o (dsr_s[i+1])
    );
  end

  assign quo_o = dvd_s[N];
  assign rem_o = rem_s[N];

endmodule

// File: rtl/rad_ctx_pipe.sv
// rad_ctx_pipe: delay line for item valid and context beside a divider row.
// Depends on rad_pkg.
module rad_ctx_pipe #(
  parameter int DEPTH = 51
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  rad_pkg::rad_ctx_t ctx_i,
  output logic             vld_o,
  output rad_pkg::rad_ctx_t ctx_o
);

  logic              vld_r [0:DEPTH-1];
  rad_pkg::rad_ctx_t ctx_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_i;
      for (int i = 1; i < DEPTH; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  assign vld_o = vld_r[DEPTH-1];
  assign ctx_o = ctx_r[DEPTH-1];

endmodule

// File: rtl/rotation_angle_alu.sv
// rotation_angle_alu: top level of the angle arithmetic unit.
// Depends on rad_pkg, rad_div_chain (rad_div_cell) and rad_ctx_pipe.
//
// Stateless angle ALU on (rotations, millidegrees) pairs. It takes one
// operation per cycle while not stalled and returns exactly one result per
// operation, in order. The depth is set by two rows of restoring-division
// cells: a 51-cell row that divides by the scale register or by 360000
// (normalize fold, rotation scaling, 360000/scale), then a 32-cell row that
// divides the low-resolution input by 360000/scale. Throughput is one
// transfer per cycle; the whole pipeline holds only while a finished result
// waits with out_stall high. Write cfg_wdata (scale) only when no transfer is
// in flight; F2, the first division row, M1, M2 and the output stage read
// scale_r directly.
module rotation_angle_alu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rad_pkg::rad_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rad_pkg::rad_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [rad_pkg::SCALE_W-1:0]    cfg_wdata
);

  localparam int AW = rad_pkg::ANG_W;
  localparam int PW = rad_pkg::PROD_W;
  localparam int SW = rad_pkg::SCALE_W;
  localparam int DW = rad_pkg::DIV_W;
  localparam int KW = rad_pkg::K_W;

  // Pipeline advance: move everything unless a result waits on a stall.
  logic en;

  logic [SW-1:0] scale_r;

  // Stage F1: operand sums and multiplier operand.
  logic              f1_vld_r;
  rad_pkg::rad_ctx_t f1_ctx_r, f1_ctx_nxt;
  logic [AW-1:0]     f1_mul_r, f1_mul_nxt;
  logic signed [AW-1:0] a_rot, a_mdg, b_rot, b_mdg;

  // Stage F2: divider operands.
  logic              f2_vld_r;
  rad_pkg::rad_ctx_t f2_ctx_r, f2_ctx_nxt;
  logic [PW-1:0]     f2_dvda_r, f2_dvda_nxt;
  logic [PW-1:0]     f2_dvdb_r, f2_dvdb_nxt;
  logic [SW-1:0]     f2_dsrb_r, f2_dsrb_nxt;
  logic [PW-1:0]     prod;
  logic signed [AW-1:0] half, vb, vb_mag, x_norm;

  // First division row outputs.
  logic              c1_vld;
  rad_pkg::rad_ctx_t c1_ctx;
  logic [PW-1:0]     c1_qa, c1_qb;

  // Stage M1: normalize fold, low-resolution sum.
  logic              m1_vld_r;
  rad_pkg::rad_ctx_t m1_ctx_r, m1_ctx_nxt;
  logic [KW-1:0]     k;
  logic [AW-1:0]     km;
  logic [AW-1:0]     rc, mc;

  // Stage M2: per-command finish, second divider operands.
  logic              m2_vld_r;
  rad_pkg::rad_ctx_t m2_ctx_r, m2_ctx_nxt;
  logic [AW-1:0]     m2_dvd_r, m2_dvd_nxt;
  logic [DW-1:0]     m2_dsr_r, m2_dsr_nxt;
  logic signed [AW-1:0] mh_sum, rh_sum, odd_add;

  // Second division row outputs.
  logic              c2_vld;
  rad_pkg::rad_ctx_t c2_ctx;
  logic [AW-1:0]     c2_q;
  logic [DW-1:0]     c2_rem;

  // Stage B1: signs of the low-resolution split.
  logic              b1_vld_r;
  rad_pkg::rad_ctx_t b1_ctx_r, b1_ctx_nxt;
  logic [AW-1:0]     rem_x;

  // Output register.
  logic              out_valid_r;
  rad_pkg::rad_out_t out_data_r, out_data_nxt;
  logic signed [2*AW-1:0] mprod;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Scale register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= rad_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // F1: per-part sum or difference; |a_rotations| for scaling, or the rotation difference for diff.
  assign a_rot = in_data.a_rotations;
  assign a_mdg = in_data.a_millideg;
  assign b_rot = in_data.b_rotations;
  assign b_mdg = in_data.b_millideg;

  always_comb begin
    f1_ctx_nxt       = '0;
    f1_ctx_nxt.cmd   = rad_pkg::rad_cmd_t'(in_data.cmd);
    f1_ctx_nxt.r     = a_rot;
    f1_ctx_nxt.m     = a_mdg;
    f1_ctx_nxt.vin   = in_data.value_in;
    f1_ctx_nxt.neg_a = a_rot[AW-1];
    f1_mul_nxt       = a_rot[AW-1] ? -a_rot : a_rot;
    case (rad_pkg::rad_cmd_t'(in_data.cmd))
      rad_pkg::CMD_DIFF: begin
        f1_ctx_nxt.r = a_rot - b_rot;
        f1_ctx_nxt.m = a_mdg - b_mdg;
        f1_mul_nxt   = a_rot - b_rot;
      end
      rad_pkg::CMD_SUM, rad_pkg::CMD_AVG: begin
        f1_ctx_nxt.r = a_rot + b_rot;
        f1_ctx_nxt.m = a_mdg + b_mdg;
      end
      default: ;
    endcase
  end

  // F2: multiply by 360000 and pick each lane's dividend and divisor.
  assign prod   = {{(PW-AW){1'b0}}, f1_mul_r} * rad_pkg::MDEG_ROT_P;
  assign half   = {2'b00, scale_r[SW-1:1]};
  assign vb     = (f1_ctx_r.m > 0) ? f1_ctx_r.m + half :
                  (f1_ctx_r.m < 0) ? f1_ctx_r.m - half : f1_ctx_r.m;
  assign vb_mag = vb[AW-1] ? -vb : vb;
  assign x_norm = (f1_ctx_r.m > rad_pkg::MDEG_ROT)  ? f1_ctx_r.m - 1 :
                  (f1_ctx_r.m < -rad_pkg::MDEG_ROT) ? ~f1_ctx_r.m : '0;

  always_comb begin
    f2_ctx_nxt  = f1_ctx_r;
    f2_dvda_nxt = '0;
    f2_dvdb_nxt = '0;
    f2_dsrb_nxt = SW'(rad_pkg::MDEG_ROT);
    case (f1_ctx_r.cmd)
      rad_pkg::CMD_DIFF, rad_pkg::CMD_SUM, rad_pkg::CMD_AVG,
      rad_pkg::CMD_ADD_MDEG: begin
        f2_dvdb_nxt = {{(PW-AW){1'b0}}, x_norm};
        if (f1_ctx_r.cmd == rad_pkg::CMD_DIFF) f2_ctx_nxt.v = prod[AW-1:0];
      end
      rad_pkg::CMD_TO_LOW_RES: begin
        f2_dvda_nxt      = prod;
        f2_dvdb_nxt      = {{(PW-AW){1'b0}}, vb_mag};
        f2_dsrb_nxt      = scale_r;
        f2_ctx_nxt.neg_b = vb[AW-1];
      end
      rad_pkg::CMD_FROM_LOW_RES: begin
        f2_dvda_nxt = rad_pkg::MDEG_ROT_P;
      end
      default: ;
    endcase
  end

  // Lane A: scaled rotations or 360000 over scale. Lane B: normalize fold
  // count, or the rounded millidegree part over scale.
  rad_div_chain #(.N(PW), .D(SW)) u_chain_a (
    .clk   (clk),
    .en    (en),
    .dvd_i (f2_dvda_r),
    .dsr_i (scale_r),
    .quo_o (c1_qa),
    .rem_o ()
  );

  rad_div_chain #(.N(PW), .D(SW)) u_chain_b (
    .clk   (clk),
    .en    (en),
    .dvd_i (f2_dvdb_r),
    .dsr_i (f2_dsrb_r),
    .quo_o (c1_qb),
    .rem_o ()
  );

  rad_ctx_pipe #(.DEPTH(rad_pkg::CHAIN1_LEN)) u_ctx_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (f2_vld_r),
    .ctx_i (f2_ctx_r),
    .vld_o (c1_vld),
    .ctx_o (c1_ctx)
  );

  // M1: fold whole rotations out of the millidegree part; sum the low-resolution parts; latch the divisor.
  assign k  = c1_qb[KW-1:0];
  assign km = {{(AW-KW){1'b0}}, k} * rad_pkg::MDEG_ROT;
  assign rc = c1_ctx.neg_a ? -c1_qa[AW-1:0] : c1_qa[AW-1:0];
  assign mc = c1_ctx.neg_b ? -c1_qb[AW-1:0] : c1_qb[AW-1:0];

  always_comb begin
    m1_ctx_nxt = c1_ctx;
    case (c1_ctx.cmd)
      rad_pkg::CMD_DIFF, rad_pkg::CMD_SUM, rad_pkg::CMD_AVG,
      rad_pkg::CMD_ADD_MDEG: begin
        if (c1_ctx.m > rad_pkg::MDEG_ROT) begin
          m1_ctx_nxt.m = c1_ctx.m - km;
          m1_ctx_nxt.r = c1_ctx.r + {{(AW-KW){1'b0}}, k};
        end else if (c1_ctx.m < -rad_pkg::MDEG_ROT) begin
          m1_ctx_nxt.m = c1_ctx.m + km;
          m1_ctx_nxt.r = c1_ctx.r - {{(AW-KW){1'b0}}, k};
        end
        if (c1_ctx.cmd == rad_pkg::CMD_DIFF) m1_ctx_nxt.v = c1_ctx.v + c1_ctx.m;
      end
      rad_pkg::CMD_TO_LOW_RES: begin
        m1_ctx_nxt.v = (scale_r != '0) ? rc + mc : '0;
      end
      rad_pkg::CMD_FROM_LOW_RES: begin
        m1_ctx_nxt.d = c1_qa[DW-1:0];
      end
      default: ;
    endcase
  end

  // M2: finish every command but from_low_res; set up its division.
  assign mh_sum  = m1_ctx_r.m + $signed({{(AW-1){1'b0}}, m1_ctx_r.m[AW-1] & m1_ctx_r.m[0]});
  assign rh_sum  = m1_ctx_r.r + $signed({{(AW-1){1'b0}}, m1_ctx_r.r[AW-1] & m1_ctx_r.r[0]});
  assign odd_add = !m1_ctx_r.r[0]    ? '0 :
                   m1_ctx_r.r[AW-1]  ? -rad_pkg::HALF_ROT : rad_pkg::HALF_ROT;

  always_comb begin
    m2_ctx_nxt = m1_ctx_r;
    m2_dvd_nxt = '0;
    m2_dsr_nxt = m1_ctx_r.d;
    case (m1_ctx_r.cmd)
      rad_pkg::CMD_DIFF: begin
        m2_ctx_nxt.near_zero = (m1_ctx_r.r < rad_pkg::SMALL_LIMIT) &&
                               (m1_ctx_r.r > -rad_pkg::SMALL_LIMIT);
      end
      rad_pkg::CMD_SUM: begin
        m2_ctx_nxt.v = '0;
      end
      rad_pkg::CMD_AVG: begin
        m2_ctx_nxt.m = (mh_sum >>> 1) + odd_add;
        m2_ctx_nxt.r = rh_sum >>> 1;
        m2_ctx_nxt.v = '0;
      end
      rad_pkg::CMD_ADD_MDEG: begin
        m2_ctx_nxt.m = m1_ctx_r.m + m1_ctx_r.vin;
        m2_ctx_nxt.v = '0;
      end
      rad_pkg::CMD_NEGATE: begin
        m2_ctx_nxt.r = -m1_ctx_r.r;
        m2_ctx_nxt.m = -m1_ctx_r.m;
        m2_ctx_nxt.v = '0;
      end
      rad_pkg::CMD_TO_LOW_RES: begin
        m2_ctx_nxt.r = '0;
        m2_ctx_nxt.m = '0;
      end
      rad_pkg::CMD_FROM_LOW_RES: begin
        m2_ctx_nxt.ok    = (scale_r != '0) && (scale_r <= rad_pkg::SCALE_MAX);
        m2_ctx_nxt.neg_a = m1_ctx_r.vin[AW-1];
        m2_ctx_nxt.v     = '0;
        m2_dvd_nxt       = m1_ctx_r.vin[AW-1] ? -m1_ctx_r.vin : m1_ctx_r.vin;
      end
      default: begin
        m2_ctx_nxt.r = '0;
        m2_ctx_nxt.m = '0;
        m2_ctx_nxt.v = '0;
      end
    endcase
  end

  // Low-resolution value over 360000/scale.
  rad_div_chain #(.N(AW), .D(DW)) u_chain_c (
    .clk   (clk),
    .en    (en),
    .dvd_i (m2_dvd_r),
    .dsr_i (m2_dsr_r),
    .quo_o (c2_q),
    .rem_o (c2_rem)
  );

  rad_ctx_pipe #(.DEPTH(rad_pkg::CHAIN2_LEN)) u_ctx_c (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (m2_vld_r),
    .ctx_i (m2_ctx_r),
    .vld_o (c2_vld),
    .ctx_o (c2_ctx)
  );

  // B1: quotient and remainder take the sign of the input (truncation).
  assign rem_x = {{(AW-DW){1'b0}}, c2_rem};

  always_comb begin
    b1_ctx_nxt = c2_ctx;
    if (c2_ctx.cmd == rad_pkg::CMD_FROM_LOW_RES && c2_ctx.ok) begin
      b1_ctx_nxt.r = c2_ctx.neg_a ? -c2_q : c2_q;
      b1_ctx_nxt.m = c2_ctx.neg_a ? -rem_x : rem_x;
    end
  end

  // Output: remainder times scale for from_low_res.
  assign mprod = b1_ctx_r.m * $signed({1'b0, scale_r});

  always_comb begin
    out_data_nxt.res_rotations = b1_ctx_r.r;
    out_data_nxt.res_millideg  = b1_ctx_r.m;
    out_data_nxt.value_out     = b1_ctx_r.v;
    out_data_nxt.diff_small    = b1_ctx_r.near_zero;
    if (b1_ctx_r.cmd == rad_pkg::CMD_FROM_LOW_RES && b1_ctx_r.ok) begin
      out_data_nxt.res_millideg = mprod[AW-1:0];
    end
  end

  // Valid bits: advance with the pipeline, drop on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      f2_vld_r    <= 1'b0;
      m1_vld_r    <= 1'b0;
      m2_vld_r    <= 1'b0;
      b1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      f1_vld_r    <= in_valid;
      f2_vld_r    <= f1_vld_r;
      m1_vld_r    <= c1_vld;
      m2_vld_r    <= m1_vld_r;
      b1_vld_r    <= c2_vld;
      out_valid_r <= b1_vld_r;
    end
  end

  // Payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctx_r   <= f1_ctx_nxt;
      f1_mul_r   <= f1_mul_nxt;
      f2_ctx_r   <= f2_ctx_nxt;
      f2_dvda_r  <= f2_dvda_nxt;
      f2_dvdb_r  <= f2_dvdb_nxt;
      f2_dsrb_r  <= f2_dsrb_nxt;
      m1_ctx_r   <= m1_ctx_nxt;
      m2_ctx_r   <= m2_ctx_nxt;
      m2_dvd_r   <= m2_dvd_nxt;
      m2_dsr_r   <= m2_dsr_nxt;
      b1_ctx_r   <= b1_ctx_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The small flag only accompanies rotations inside the limit.
  a_small_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.diff_small |->
      (out_data.res_rotations < rad_pkg::SMALL_LIMIT) &&
      (out_data.res_rotations > -rad_pkg::SMALL_LIMIT))
    else $error("diff_small set outside the rotation limit");

  // Division remainder stays below its divisor for a valid split.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c2_vld && (c2_ctx.cmd == rad_pkg::CMD_FROM_LOW_RES) && c2_ctx.ok |->
      (c2_rem < c2_ctx.d))
    else $error("low-resolution remainder not below divisor");

  // A transfer in always enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> f1_vld_r)
    else $error("accepted item missing from first stage");
`endif

endmodule
